// File: hw/rtl/ufc_pkg.sv
// Shared types, codes and constants for the UART frame codec with receive ring.
// Used by ufc_codec, ufc_ring and uart_frame_codec_with_rx_fifo. No dependencies.
`default_nettype none

package ufc_pkg;

	localparam int RING_DEPTH = 64;
	localparam int PTR_W      = $clog2(RING_DEPTH);
	localparam int FILL_W     = 6;
	localparam int WORD_BITS  = 32;
	localparam int FRAME_W    = 11;

	typedef enum logic [1:0] {
		OP_RX   = 2'd0,
		OP_READ = 2'd1,
		OP_TX   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_EMPTY      = 2'd1,
		ST_PARITY_ERR = 2'd2,
		ST_FULL_DROP  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PAR_NONE = 2'd0,
		PAR_EVEN = 2'd1,
		PAR_ODD  = 2'd2
	} parity_t;

	typedef enum logic [1:0] {
		CFG_CHAR_LEN    = 2'd0,
		CFG_PARITY_MODE = 2'd1,
		CFG_STOP_CNT    = 2'd2
	} cfg_idx_t;

	localparam logic [3:0] CHAR_LEN_RST    = 4'd8;
	localparam logic [1:0] PARITY_MODE_RST = 2'd0;
	localparam logic [1:0] STOP_CNT_RST    = 2'd1;

	typedef struct packed {
		logic [3:0] char_len;
		logic [1:0] parity_mode;
		logic [1:0] stop_cnt;
	} cfg_t;

	typedef struct packed {
		logic               rx_good;
		logic [7:0]         rx_value;
		logic [FRAME_W-1:0] tx_frame;
		logic [3:0]         tx_bit_count;
	} codec_res_t;

	typedef struct packed {
		logic       push;
		logic       pop;
		logic [7:0] wdata;
	} ring_req_t;

	typedef struct packed {
		logic              empty;
		logic              full;
		logic [FILL_W-1:0] fill;
		logic              overflow;
	} ring_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/ufc_codec.sv
// Character decode and encode: data bit extraction, parity check and transmit framing.
// Purely combinational. Depends on ufc_pkg.
`default_nettype none

module ufc_codec (
	input  wire ufc_pkg::cfg_t       cfg,
	input  wire logic [31:0]         raw_word,
	input  wire logic [7:0]          tx_byte,
	output ufc_pkg::codec_res_t      res
);
	import ufc_pkg::*;

	logic [3:0]  nb;
	logic [1:0]  par;
	logic        two_stop;
	logic [7:0]  mask;
	logic [3:0]  samp_cnt;
	logic [5:0]  shamt;
	logic [31:0] samples;
	logic [8:0]  samples_lo;
	logic [7:0]  rx_value;
	logic        rx_odd;
	logic        rx_want;
	logic [7:0]  tx_data;
	logic        tx_odd;
	logic        tx_par;
	logic [FRAME_W-1:0] frame;
	logic [3:0]  shift;

	always_comb begin
		nb = (cfg.char_len >= 4'd5 && cfg.char_len <= 4'd8) ? cfg.char_len : 4'd8;
		par = (cfg.parity_mode == PAR_EVEN || cfg.parity_mode == PAR_ODD) ?
			cfg.parity_mode : PAR_NONE;
		two_stop = (cfg.stop_cnt == 2'd2);
		mask = ~(8'hFF << nb);

		samp_cnt = nb + ((par != PAR_NONE) ? 4'd1 : 4'd0);
		shamt = 6'(WORD_BITS) - {2'b00, samp_cnt};
		samples = raw_word >> shamt;
		samples_lo = samples[8:0];
		rx_value = samples_lo[7:0] & mask;
		rx_odd = ^rx_value;
		rx_want = (par == PAR_EVEN) ? rx_odd : ~rx_odd;
		res.rx_good = (par == PAR_NONE) || (samples_lo[nb] == rx_want);
		res.rx_value = rx_value;

		tx_data = tx_byte & mask;
		tx_odd = ^tx_data;
		tx_par = (par == PAR_EVEN) ? tx_odd : ~tx_odd;
		frame = FRAME_W'(tx_data);
		shift = nb;
		if (par != PAR_NONE) begin
			frame = frame | (FRAME_W'(tx_par) << shift);
			shift = shift + 4'd1;
		end
		frame = frame | (FRAME_W'(1) << shift);
		shift = shift + 4'd1;
		if (two_stop) begin
			frame = frame | (FRAME_W'(1) << shift);
			shift = shift + 4'd1;
		end
		res.tx_frame = frame;
		res.tx_bit_count = shift;
	end

endmodule

`default_nettype wire

// File: hw/rtl/ufc_ring.sv
// Receive ring: byte memory, read and write pointers, fill count and sticky overflow flag.
// Read data is registered. Depends on ufc_pkg.
`default_nettype none

module ufc_ring (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ufc_pkg::ring_req_t  req,
	output ufc_pkg::ring_stat_t      stat,
	output logic [7:0]               rdata_q
);
	import ufc_pkg::*;

	logic [7:0]       mem [RING_DEPTH];
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic             ovf_q;
	logic [PTR_W-1:0] wp_adv;
	logic [PTR_W-1:0] rp_adv;
	logic [PTR_W-1:0] wp_n;
	logic [PTR_W-1:0] rp_n;
	logic             ovf_n;
	logic             empty;
	logic             full;
	logic             do_push;
	logic             do_pop;
	logic [PTR_W:0]   diff;

	always_comb begin
		wp_adv = (wp_q == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
		rp_adv = (rp_q == PTR_W'(RING_DEPTH - 1)) ? '0 : rp_q + PTR_W'(1);
		empty = (rp_q == wp_q);
		full = (wp_adv == rp_q);
		do_push = req.push && !full;
		do_pop = req.pop && !empty;
		wp_n = do_push ? wp_adv : wp_q;
		rp_n = do_pop ? rp_adv : rp_q;
		ovf_n = ovf_q | (req.push & full);
		diff = {1'b0, wp_n} - {1'b0, rp_n};
		if (wp_n < rp_n) begin
			diff = diff + (PTR_W + 1)'(RING_DEPTH);
		end
		stat.empty = empty;
		stat.full = full;
		stat.fill = FILL_W'(diff);
		stat.overflow = ovf_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			wp_q <= wp_n;
			rp_q <= rp_n;
			ovf_q <= ovf_n;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wp_q] <= req.wdata;
		end
		if (do_pop) begin
			rdata_q <= mem[rp_q];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/uart_frame_codec_with_rx_fifo.sv
// Top level of the UART frame codec: input register, configuration registers and result register.
// Instantiates ufc_codec and ufc_ring. Depends on ufc_pkg.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+-----------------------------------------------
//   in      | in_valid / in_stall  | opcode, raw_word, tx_byte
//   out     | out_valid / out_stall| status, read_byte, tx_frame, tx_bit_count,
//           |                      | fill_count, overflow_seen
//   cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A transaction is captured in the input register and decoded in the next cycle; its result
// is loaded into the result register when that register can advance, and is presented from
// there. One transaction per cycle is sustained while out_stall is low. The ring push or pop
// and the registered memory read happen in the decode cycle. Reset clears the pointers and the
// overflow flag and returns the configuration to its defaults. A stalled result holds while one
// more transaction waits in the input register.
`default_nettype none

module uart_frame_codec_with_rx_fifo (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic [31:0] raw_word,
	input  wire logic [7:0]  tx_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [7:0]       read_byte,
	output logic [10:0]      tx_frame,
	output logic [3:0]       tx_bit_count,
	output logic [5:0]       fill_count,
	output logic             overflow_seen,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [3:0]  cfg_data
);
	import ufc_pkg::*;

	cfg_t       cfg_q;
	logic       valid_s1;
	logic [1:0] opcode_s1;
	logic [31:0] raw_word_s1;
	logic [7:0] tx_byte_s1;
	logic       valid_s2;
	logic [1:0] status_s2;
	logic       read_ok_s2;
	logic [FRAME_W-1:0] tx_frame_s2;
	logic [3:0] tx_bit_count_s2;
	logic [FILL_W-1:0] fill_s2;
	logic       ovf_s2;
	logic       advance;
	logic       fire;
	logic       accept;
	codec_res_t codec_res;
	ring_req_t  ring_req;
	ring_stat_t ring_stat;
	logic [7:0] ring_rdata;
	logic [1:0] status_d;

	assign cfg_ready = 1'b1;
	assign advance = !valid_s2 || !out_stall;
	assign fire = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.char_len <= CHAR_LEN_RST;
			cfg_q.parity_mode <= PARITY_MODE_RST;
			cfg_q.stop_cnt <= STOP_CNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CHAR_LEN:    cfg_q.char_len <= cfg_data;
				CFG_PARITY_MODE: cfg_q.parity_mode <= cfg_data[1:0];
				CFG_STOP_CNT:    cfg_q.stop_cnt <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1 <= opcode;
			raw_word_s1 <= raw_word;
			tx_byte_s1 <= tx_byte;
		end
	end

	ufc_codec u_codec (
		.cfg      (cfg_q),
		.raw_word (raw_word_s1),
		.tx_byte  (tx_byte_s1),
		.res      (codec_res)
	);

	always_comb begin
		ring_req.push = fire && (opcode_s1 == OP_RX) && codec_res.rx_good;
		ring_req.pop = fire && (opcode_s1 == OP_READ);
		ring_req.wdata = codec_res.rx_value;
	end

	ufc_ring u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (ring_req),
		.stat    (ring_stat),
		.rdata_q (ring_rdata)
	);

	always_comb begin
		case (opcode_s1)
			OP_RX: begin
				if (!codec_res.rx_good) begin
					status_d = ST_PARITY_ERR;
				end else if (ring_stat.full) begin
					status_d = ST_FULL_DROP;
				end else begin
					status_d = ST_OK;
				end
			end
			OP_READ: status_d = ring_stat.empty ? ST_EMPTY : ST_OK;
			default: status_d = ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_s2 <= status_d;
			read_ok_s2 <= (opcode_s1 == OP_READ) && !ring_stat.empty;
			tx_frame_s2 <= (opcode_s1 == OP_TX) ? codec_res.tx_frame : '0;
			tx_bit_count_s2 <= (opcode_s1 == OP_TX) ? codec_res.tx_bit_count : '0;
			fill_s2 <= ring_stat.fill;
			ovf_s2 <= ring_stat.overflow;
		end
	end

	assign out_valid = valid_s2;
	assign status = status_s2;
	assign read_byte = read_ok_s2 ? ring_rdata : 8'd0;
	assign tx_frame = tx_frame_s2;
	assign tx_bit_count = tx_bit_count_s2;
	assign fill_count = fill_s2;
	assign overflow_seen = ovf_s2;

endmodule

`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for uart_frame_codec_with_rx_fifo: a directed table, then random phases.
// Each accepted transaction is predicted by a local model of the receive ring and framing logic.
// Depends on ufc_pkg and the RTL of the codec.
module testbench;

	import ufc_pkg::*;

	localparam logic [1:0] OP_SPARE    = 2'd3;
	localparam logic [1:0] CFG_SPARE   = 2'd3;
	localparam logic [1:0] PAR_SPARE   = 2'd3;
	localparam int         PHASES      = 24;
	localparam int         STUCK_LIMIT = 2000;
	localparam int         TAIL_CYCLES = 12;
	localparam int         PRINT_CAP   = 100;

	typedef enum int {
		LOAD_FILL,
		LOAD_DRAIN,
		LOAD_MIXED,
		LOAD_NOISY
	} load_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  read_byte;
		logic [10:0] tx_frame;
		logic [3:0]  tx_bit_count;
		logic [5:0]  fill_count;
		logic        overflow_seen;
	} char_result_t;

	// A row either writes a register (code is the index, data holds the value)
	// or sends one transaction (code is the opcode).
	typedef struct packed {
		logic         is_cfg;
		logic [1:0]   code;
		logic [31:0]  raw;
		logic [7:0]   data;
		logic         typed;
		char_result_t want;
	} stim_row_t;

	localparam stim_row_t DIRECTED [33] = '{
		'{1'b0, OP_READ, 32'h0000_0000, 8'h00, 1'b1, '{ST_EMPTY, 8'h00, 11'h000, 4'd0, 6'd0, 1'b0}},
		'{1'b0, OP_SPARE, 32'hFFFF_FFFF, 8'hFF, 1'b1, '{ST_OK, 8'h00, 11'h000, 4'd0, 6'd0, 1'b0}},
		'{1'b0, OP_TX, 32'h0000_0000, 8'h00, 1'b1, '{ST_OK, 8'h00, 11'h100, 4'd9, 6'd0, 1'b0}},
		'{1'b0, OP_TX, 32'hFFFF_FFFF, 8'hFF, 1'b1, '{ST_OK, 8'h00, 11'h1FF, 4'd9, 6'd0, 1'b0}},
		'{1'b0, OP_RX, 32'hFFFF_FFFF, 8'h00, 1'b1, '{ST_OK, 8'h00, 11'h000, 4'd0, 6'd1, 1'b0}},
		'{1'b0, OP_RX, 32'h0000_0000, 8'hA5, 1'b1, '{ST_OK, 8'h00, 11'h000, 4'd0, 6'd2, 1'b0}},
		'{1'b0, OP_RX, 32'hA5C3_0F96, 8'h00, 1'b0, '0},
		'{1'b0, OP_READ, 32'h0000_0000, 8'h00, 1'b1, '{ST_OK, 8'hFF, 11'h000, 4'd0, 6'd2, 1'b0}},
		'{1'b0, OP_READ, 32'h0000_0000, 8'h00, 1'b1, '{ST_OK, 8'h00, 11'h000, 4'd0, 6'd1, 1'b0}},
		'{1'b0, OP_READ, 32'h0000_0000, 8'h00, 1'b0, '0},
		'{1'b0, OP_READ, 32'h0000_0000, 8'h00, 1'b1, '{ST_EMPTY, 8'h00, 11'h000, 4'd0, 6'd0, 1'b0}},
		'{1'b1, CFG_CHAR_LEN, 32'h0, 8'h05, 1'b0, '0},
		'{1'b1, CFG_PARITY_MODE, 32'h0, 8'h01, 1'b0, '0},
		'{1'b1, CFG_STOP_CNT, 32'h0, 8'h02, 1'b0, '0},
		'{1'b0, OP_TX, 32'h0000_0000, 8'hFF, 1'b0, '0},
		'{1'b0, OP_RX, 32'hF800_0000, 8'h00, 1'b1, '{ST_PARITY_ERR, 8'h00, 11'h000, 4'd0, 6'd0, 1'b0}},
		'{1'b0, OP_RX, 32'hFC00_0000, 8'h00, 1'b0, '0},
		'{1'b1, CFG_PARITY_MODE, 32'h0, 8'h0E, 1'b0, '0},
		'{1'b1, CFG_CHAR_LEN, 32'h0, 8'h0F, 1'b0, '0},
		'{1'b0, OP_TX, 32'h0000_0000, 8'h00, 1'b1, '{ST_OK, 8'h00, 11'h700, 4'd11, 6'd1, 1'b0}},
		'{1'b0, OP_RX, 32'h0000_0000, 8'h00, 1'b1, '{ST_PARITY_ERR, 8'h00, 11'h000, 4'd0, 6'd1, 1'b0}},
		'{1'b1, CFG_PARITY_MODE, 32'h0, 8'h03, 1'b0, '0},
		'{1'b1, CFG_STOP_CNT, 32'h0, 8'h00, 1'b0, '0},
		'{1'b1, CFG_CHAR_LEN, 32'h0, 8'h05, 1'b0, '0},
		'{1'b0, OP_TX, 32'h0000_0000, 8'hFF, 1'b1, '{ST_OK, 8'h00, 11'h03F, 4'd6, 6'd1, 1'b0}},
		'{1'b1, CFG_CHAR_LEN, 32'h0, 8'h00, 1'b0, '0},
		'{1'b1, CFG_STOP_CNT, 32'h0, 8'h03, 1'b0, '0},
		'{1'b1, CFG_SPARE, 32'h0, 8'h0F, 1'b0, '0},
		'{1'b0, OP_RX, 32'h7FFF_FFFF, 8'h00, 1'b0, '0},
		'{1'b0, OP_TX, 32'h0000_0000, 8'h80, 1'b0, '0},
		'{1'b0, OP_READ, 32'h0000_0000, 8'h00, 1'b0, '0},
		'{1'b0, OP_READ, 32'h0000_0000, 8'h00, 1'b0, '0},
		'{1'b0, OP_READ, 32'h0000_0000, 8'h00, 1'b1, '{ST_EMPTY, 8'h00, 11'h000, 4'd0, 6'd0, 1'b0}}
	};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic [1:0]  opcode    = OP_RX;
	logic [31:0] raw_word  = '0;
	logic [7:0]  tx_byte   = '0;
	logic        out_stall = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [1:0]  cfg_index = CFG_CHAR_LEN;
	logic [3:0]  cfg_data  = '0;
	logic        in_stall;
	logic        out_valid;
	logic [1:0]  status;
	logic [7:0]  read_byte;
	logic [10:0] tx_frame;
	logic [3:0]  tx_bit_count;
	logic [5:0]  fill_count;
	logic        overflow_seen;
	logic        cfg_ready;

	// Side information that travels with the payload of a directed row.
	logic         row_typed = 1'b0;
	char_result_t row_want  = '0;

	logic [7:0] ring_copy [RING_DEPTH];
	int         rd_idx = 0;
	int         wr_idx = 0;
	logic       ovf_sticky = 1'b0;
	logic [3:0] reg_char_len  = CHAR_LEN_RST;
	logic [1:0] reg_parity    = PARITY_MODE_RST;
	logic [1:0] reg_stop      = STOP_CNT_RST;
	logic [3:0] stim_char_len  = CHAR_LEN_RST;
	logic [1:0] stim_parity    = PARITY_MODE_RST;

	char_result_t results_due [$];
	char_result_t predicted;
	char_result_t observed;
	int chars_issued    = 0;
	int results_checked = 0;
	int mismatch_count  = 0;
	int stuck_cycles    = 0;
	int stall_left      = 0;
	bit sender_quiet    = 1'b0;
	logic hush_stalls   = 1'b0;
	int n_rx = 0, n_read = 0, n_tx = 0, n_spare = 0;
	int n_parity_drop = 0, n_full_drop = 0, n_empty = 0, peak_fill = 0;

	uart_frame_codec_with_rx_fifo i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.raw_word     (raw_word),
		.tx_byte      (tx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.read_byte    (read_byte),
		.tx_frame     (tx_frame),
		.tx_bit_count (tx_bit_count),
		.fill_count   (fill_count),
		.overflow_seen(overflow_seen),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int char_width(logic [3:0] v);
		return (v >= 4'd5 && v <= 4'd8) ? int'(v) : 8;
	endfunction

	function automatic parity_t parity_kind(logic [1:0] v);
		return (v == PAR_EVEN || v == PAR_ODD) ? parity_t'(v) : PAR_NONE;
	endfunction

	function automatic char_result_t apply_char(logic [1:0] op, logic [31:0] raw, logic [7:0] txb);
		char_result_t r;
		int           nb;
		int           shift;
		int           nxt;
		parity_t      pk;
		logic [31:0]  samples;
		logic [7:0]   mask;
		logic [7:0]   value;
		logic         want;
		r = '0;
		nb = char_width(reg_char_len);
		pk = parity_kind(reg_parity);
		mask = 8'((1 << nb) - 1);
		case (op)
			OP_RX: begin
				samples = raw >> (32 - nb - ((pk != PAR_NONE) ? 1 : 0));
				value = samples[7:0] & mask;
				want = (pk == PAR_EVEN) ? ^value : ~^value;
				if (pk != PAR_NONE && samples[nb] != want) begin
					r.status = ST_PARITY_ERR;
				end else begin
					nxt = (wr_idx + 1) % RING_DEPTH;
					if (nxt == rd_idx) begin
						ovf_sticky = 1'b1;
						r.status = ST_FULL_DROP;
					end else begin
						ring_copy[wr_idx] = value;
						wr_idx = nxt;
					end
				end
			end
			OP_READ: begin
				if (rd_idx == wr_idx) begin
					r.status = ST_EMPTY;
				end else begin
					r.read_byte = ring_copy[rd_idx];
					rd_idx = (rd_idx + 1) % RING_DEPTH;
				end
			end
			OP_TX: begin
				value = txb & mask;
				r.tx_frame = {3'b000, value};
				shift = nb;
				if (pk != PAR_NONE) begin
					r.tx_frame[shift] = (pk == PAR_EVEN) ? ^value : ~^value;
					shift++;
				end
				repeat ((reg_stop == 2'd2) ? 2 : 1) begin
					r.tx_frame[shift] = 1'b1;
					shift++;
				end
				r.tx_bit_count = 4'(shift);
			end
			default: ;
		endcase
		r.fill_count = 6'((wr_idx + RING_DEPTH - rd_idx) % RING_DEPTH);
		r.overflow_seen = ovf_sticky;
		return r;
	endfunction

	// Builds a sampled line word for the current character format, with a good
	// parity bit unless it is to be spoiled, and random bits below the sample.
	function automatic logic [31:0] line_word(logic [7:0] value, bit spoil);
		int          nb;
		int          nsb;
		parity_t     pk;
		logic [8:0]  samples;
		logic [31:0] noise;
		nb = char_width(stim_char_len);
		pk = parity_kind(stim_parity);
		samples = {1'b0, value} & 9'((1 << nb) - 1);
		nsb = nb;
		if (pk != PAR_NONE) begin
			samples[nb] = ((pk == PAR_EVEN) ? ^samples[7:0] : ~^samples[7:0]) ^ spoil;
			nsb = nb + 1;
		end
		noise = $urandom;
		return ({23'b0, samples} << (32 - nsb)) | (noise & (32'hFFFF_FFFF >> nsb));
	endfunction

	function automatic int sender_gap();
		int pick;
		if (sender_quiet)
			return 0;
		pick = $urandom_range(99);
		if (pick < 65)
			return 0;
		if (pick < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 6);
	endfunction

	task automatic note_mismatch(string field, int unsigned got, int unsigned want);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("mismatch in %s at result %0d: got 0x%0h, expected 0x%0h",
				field, results_checked, got, want);
	endtask

	task automatic check_result(char_result_t got, char_result_t want);
		if (got.status != want.status)
			note_mismatch("status", got.status, want.status);
		if (got.read_byte != want.read_byte)
			note_mismatch("read_byte", got.read_byte, want.read_byte);
		if (got.tx_frame != want.tx_frame)
			note_mismatch("tx_frame", got.tx_frame, want.tx_frame);
		if (got.tx_bit_count != want.tx_bit_count)
			note_mismatch("tx_bit_count", got.tx_bit_count, want.tx_bit_count);
		if (got.fill_count != want.fill_count)
			note_mismatch("fill_count", got.fill_count, want.fill_count);
		if (got.overflow_seen != want.overflow_seen)
			note_mismatch("overflow_seen", got.overflow_seen, want.overflow_seen);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_CHAR_LEN:    reg_char_len = cfg_data;
					CFG_PARITY_MODE: reg_parity = cfg_data[1:0];
					CFG_STOP_CNT:    reg_stop = cfg_data[1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				predicted = apply_char(opcode, raw_word, tx_byte);
				results_due.push_back(row_typed ? row_want : predicted);
				case (opcode)
					OP_RX:   n_rx++;
					OP_READ: n_read++;
					OP_TX:   n_tx++;
					default: n_spare++;
				endcase
				case (predicted.status)
					ST_EMPTY:      n_empty++;
					ST_PARITY_ERR: n_parity_drop++;
					ST_FULL_DROP:  n_full_drop++;
					default: ;
				endcase
				if (predicted.fill_count > peak_fill)
					peak_fill = predicted.fill_count;
			end
			if (out_valid && !out_stall) begin
				results_checked++;
				observed = '{status_t'(status), read_byte, tx_frame, tx_bit_count,
					fill_count, overflow_seen};
				if (results_due.size() == 0)
					note_mismatch("unrequested result", status, 0);
				else
					check_result(observed, results_due.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (hush_stalls || !arst_n) begin
			stall_left = 0;
			out_stall <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			case ($urandom_range(19))
				0, 1, 2, 3, 4: begin
					stall_left = $urandom_range(2);
					out_stall <= 1'b1;
				end
				5: begin
					stall_left = $urandom_range(47, 8);
					out_stall <= 1'b1;
				end
				default: out_stall <= 1'b0;
			endcase
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("timeout after %0d cycles without a transaction", STUCK_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic idle_sender(int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_item(logic [1:0] op, logic [31:0] raw, logic [7:0] txb, logic typed,
			char_result_t want);
		in_valid <= 1'b1;
		opcode <= op;
		raw_word <= raw;
		tx_byte <= txb;
		row_typed <= typed;
		row_want <= want;
		do @(posedge clk); while (in_stall);
		chars_issued++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (results_checked < chars_issued) @(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [3:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx == CFG_CHAR_LEN)
			stim_char_len = data;
		else if (idx == CFG_PARITY_MODE)
			stim_parity = data[1:0];
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_line(logic [3:0] width, logic [1:0] par, logic [1:0] stops, bit spare);
		wait_drained();
		cfg_write(CFG_CHAR_LEN, width);
		cfg_write(CFG_PARITY_MODE, {2'($urandom_range(3)), par});
		cfg_write(CFG_STOP_CNT, {2'($urandom_range(3)), stops});
		if (spare)
			cfg_write(CFG_SPARE, 4'($urandom));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int          phase;
		int          k;
		int          n_items;
		int          pick;
		int          rx_cut;
		int          read_cut;
		int          tx_cut;
		int          spoil_pct;
		bit          cfg_open;
		load_t       load;
		logic [1:0]  op;
		logic [31:0] raw;
		cfg_open = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].is_cfg) begin
				if (!cfg_open)
					wait_drained();
				cfg_write(DIRECTED[i].code, DIRECTED[i].data[3:0]);
				cfg_open = 1'b1;
			end else begin
				if (cfg_open) begin
					cfg_valid <= 1'b0;
					cfg_open = 1'b0;
				end
				idle_sender(sender_gap());
				send_item(DIRECTED[i].code, DIRECTED[i].raw, DIRECTED[i].data,
					DIRECTED[i].typed, DIRECTED[i].want);
			end
		end

		for (phase = 0; phase < PHASES; phase++) begin
			load = load_t'(phase % 4);
			case (phase)
				0: set_line(4'd5, PAR_EVEN, 2'd2, 1'b0);
				1: set_line(4'd8, PAR_ODD, 2'd1, 1'b1);
				2: set_line(4'd8, PAR_SPARE, 2'd0, 1'b0);
				3: set_line(4'd5, PAR_NONE, 2'd3, 1'b0);
				default: set_line(($urandom_range(99) < 75) ? 4'($urandom_range(8, 5))
					: 4'($urandom_range(15)), 2'($urandom_range(3)), 2'($urandom_range(3)),
					phase % 3 == 1);
			endcase
			sender_quiet = (phase % 5 == 3);
			hush_stalls <= sender_quiet;
			case (load)
				LOAD_FILL:  begin rx_cut = 85; read_cut = 91; tx_cut = 97; spoil_pct = 5; end
				LOAD_DRAIN: begin rx_cut = 10; read_cut = 85; tx_cut = 97; spoil_pct = 10; end
				LOAD_MIXED: begin rx_cut = 45; read_cut = 80; tx_cut = 97; spoil_pct = 8; end
				default:    begin rx_cut = 30; read_cut = 80; tx_cut = 92; spoil_pct = 30; end
			endcase
			n_items = (load == LOAD_FILL) ? 110 : 70;
			for (k = 0; k < n_items; k++) begin
				// Once in the run the sender holds off until every issued transaction has been answered and checked.
				if (phase == 8 && k == 50)
					wait_drained();
				pick = $urandom_range(99);
				raw = $urandom;
				if (pick < rx_cut) begin
					op = OP_RX;
					if (!(load == LOAD_NOISY && $urandom_range(3) == 0))
						raw = line_word(8'($urandom), $urandom_range(99) < spoil_pct);
				end else if (pick < read_cut) begin
					op = OP_READ;
				end else if (pick < tx_cut) begin
					op = OP_TX;
				end else begin
					op = OP_SPARE;
				end
				idle_sender(sender_gap());
				send_item(op, raw, 8'($urandom), 1'b0, '0);
			end
		end

		wait_drained();
		hush_stalls <= 1'b1;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (results_due.size() != 0)
			note_mismatch("results never delivered", results_due.size(), 0);
		$display("covered %0d transactions: %0d receive, %0d read, %0d transmit, %0d spare opcode",
			chars_issued, n_rx, n_read, n_tx, n_spare);
		$display("drops: %0d parity, %0d ring full; %0d reads of an empty ring; peak fill %0d",
			n_parity_drop, n_full_drop, n_empty, peak_fill);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/ufc_pkg.sv
hw/rtl/ufc_codec.sv
hw/rtl/ufc_ring.sv
hw/rtl/uart_frame_codec_with_rx_fifo.sv
dv/testbench.sv
